>>> rtl/core/goal_bitmap_block_allocator_defines.svh
// Assertion macros for the goal bitmap block allocator.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GOAL_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define GOAL_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define GBBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gbba check failed");
`define GBBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gbba check failed");
`else
`define GBBA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GBBA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/gbba_pkg.sv
// Shared types and constants for the goal bitmap block allocator.
// No dependencies.
`timescale 1ns / 1ps

package gbba_pkg;

    localparam int WORD_BITS  = 64;
    localparam int OFF_W      = 6;
    localparam int BLK_W      = 16;
    localparam int LEN_W      = 14;
    localparam int OUT_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STS_OK,
        STS_NO_SPACE,
        STS_RANGE,
        STS_CORRUPT
    } gbba_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_START,
        ST_GOAL_RD,
        ST_GOAL_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_GRP_SEL,
        ST_BACK_RD,
        ST_BACK_LD,
        ST_COMMIT,
        ST_FR_RD,
        ST_FR_WR,
        ST_DONE
    } gbba_state_t;

endpackage

>>> rtl/core/goal_bitmap_block_allocator.sv
// Top level of the goal bitmap block allocator: control sequencer, counters, ports.
// Depends on gbba_pkg, gbba_bitmap_ram, gbba_word_scan and the defines header.
`timescale 1ns / 1ps
`include "goal_bitmap_block_allocator_defines.svh"

// Keeps a used-block bitmap of GROUPS groups of GROUP_BLOCKS blocks in one
// 64-bit-wide RAM with per-group and total free counters in flops. One
// transaction at a time: an allocate reads and checks the bitmap one word at a
// time (goal word, then the rest of the goal group, then, if it moves on, the
// groups tried in turn in the group counters, then the words of the chosen
// group). A free reads and rewrites each bitmap word the run touches.
// After reset the bitmap's GROUPS*GROUP_BLOCKS/64 words (128 by default) are
// cleared one word per cycle before s_tready rises. The user must write
// configuration only while idle; the block itself does not enforce it.
module goal_bitmap_block_allocator #(
    parameter int GROUPS       = 8,
    parameter int GROUP_BLOCKS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // block_number[15:0], run_length[29:16], privileged[30], zero pad
    input  logic [gbba_pkg::S_TDATA_W-1:0]    s_tdata,
    // op[0]
    input  logic [gbba_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // allocated_block[13:0], freed_count[27:14], double_free[28],
    // total_free[42:29], zero pad
    output logic [gbba_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [gbba_pkg::M_TUSER_W-1:0]    m_tuser
);
    import gbba_pkg::*;

    localparam int TOTAL  = GROUPS * GROUP_BLOCKS;
    localparam int WORDS  = TOTAL / WORD_BITS;
    localparam int WPG    = GROUP_BLOCKS / WORD_BITS;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW     = $clog2(GROUP_BLOCKS + 1);
    localparam int TCW    = $clog2(TOTAL + 1);
    localparam int TW     = $clog2(TOTAL + 2);
    localparam int AW     = ((TW > BLK_W + 1) ? TW : BLK_W + 1) + 1;
    localparam int CMPW   = (TCW > OUT_W) ? TCW : OUT_W;

    gbba_state_t state_reg, state_next;

    logic                 fdb_reg;
    logic [OUT_W-1:0]     rsv_reg;
    logic                 op_reg, priv_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [CW-1:0]        gfc_reg [GROUPS];
    logic [TCW-1:0]       total_reg;
    logic [WAW-1:0]       word_reg, end_word_reg, fz_word_reg, found_word_reg;
    logic [OFF_W-1:0]     off_reg, fz_off_reg, found_off_reg;
    logic [63:0]          fz_data_reg, found_data_reg, prev_data_reg;
    logic                 fz_vld_reg, prev_ok_reg, back_reg, gphase_reg;
    logic [GW-1:0]        g_reg, gcnt_reg;
    logic [AW-1:0]        rs_reg, re_reg;
    gbba_status_t         sts_reg;
    logic [OUT_W-1:0]     alloc_reg, freed_reg;
    logic                 dbl_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic                 mem_rd_en, mem_wr_en;
    logic [WAW-1:0]       mem_rd_addr, mem_wr_addr;
    logic [63:0]          mem_rd_data, mem_wr_data;

    logic [AW-1:0]        fdb_x, blk_x, len_x, zone_end, rel_start, rel_end;
    logic [AW-1:0]        goal_rel, fpos;
    logic                 free_bad, in_zone, reserve_hit;
    logic [WAW-1:0]       goal_word, fword;
    logic [OFF_W-1:0]     goal_off, scan_from;
    logic [GW-1:0]        goal_grp, grp_next, word_grp, gfc_idx;
    logic [CW-1:0]        gfc_rd;
    logic                 word_last, word_first, found_first, goal_hit, bf_need_prev;
    logic [127:0]         back_cat;
    logic [6:0]           back_bits;
    logic [5:0]           lo;
    logic [6:0]           hi;
    logic [63:0]          mask_lo, mask_hi, fmask, commit_data;
    logic                 zf_hit, bf_hit;
    logic [5:0]           zf_pos;
    logic [2:0]           bf_pos, back_cnt;
    logic [6:0]           pop;
    logic [CW:0]          gsum;
    logic [TCW:0]         tsum;
    logic                 out_load;

    gbba_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (WAW)
    ) u_ram (
        .clk     (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    gbba_word_scan u_scan (
        .word      (mem_rd_data),
        .from_off  (scan_from),
        .pop_word  (mem_rd_data & fmask),
        .back_bits (back_bits),
        .zf_hit    (zf_hit),
        .zf_pos    (zf_pos),
        .bf_hit    (bf_hit),
        .bf_pos    (bf_pos),
        .pop       (pop),
        .back_cnt  (back_cnt)
    );

    // request decode
    always_comb begin
        fdb_x       = AW'(fdb_reg);
        blk_x       = AW'(blk_reg);
        len_x       = AW'(len_reg);
        zone_end    = fdb_x + AW'(TOTAL);
        free_bad    = (blk_x < fdb_x) || (blk_x + len_x > zone_end);
        rel_start   = blk_x - fdb_x;
        rel_end     = rel_start + len_x;
        in_zone     = (blk_x >= fdb_x) && (blk_x < zone_end);
        goal_rel    = (in_zone ? blk_x : fdb_x) - fdb_x;
        goal_word   = WAW'(goal_rel >> 6);
        goal_off    = goal_rel[5:0];
        goal_grp    = GW'(goal_rel / GROUP_BLOCKS);
        reserve_hit = CMPW'(total_reg) <= CMPW'(rsv_reg);
    end

    always_comb begin
        grp_next    = (g_reg == GW'(GROUPS - 1)) ? '0 : g_reg + 1'b1;
        word_grp    = GW'(int'(word_reg) / WPG);
        word_last   = (int'(word_reg) % WPG) == (WPG - 1);
        word_first  = (int'(word_reg) % WPG) == 0;
        found_first = ((int'(found_word_reg) % WPG) == 0) && (found_off_reg == '0);
        unique case (state_reg)
            ST_START:   gfc_idx = goal_grp;
            ST_GRP_SEL: gfc_idx = grp_next;
            ST_FR_WR:   gfc_idx = word_grp;
            default:    gfc_idx = g_reg;
        endcase
        gfc_rd       = gfc_reg[gfc_idx];
        scan_from    = (state_reg == ST_GOAL_CHK) ? off_reg : '0;
        goal_hit     = zf_hit && ((off_reg != '0) || (zf_pos == '0));
        bf_need_prev = (bf_pos == '0) && !word_first;
    end

    // step back below a free byte, possibly into the previous word
    always_comb begin
        back_cat  = {found_data_reg, prev_data_reg};
        back_bits = (back_reg && !found_first) ?
                    7'(back_cat >> (7'd57 + 7'(found_off_reg))) : 7'h7f;
        fpos        = ((AW'(found_word_reg) << 6) | AW'(found_off_reg)) - AW'(back_cnt);
        fword       = WAW'(fpos >> 6);
        commit_data = ((fword == found_word_reg) ? found_data_reg : prev_data_reg)
                      | (64'd1 << fpos[5:0]);
    end

    // free run mask within the current word
    always_comb begin
        lo      = (word_reg == WAW'(rs_reg >> 6)) ? rs_reg[5:0] : 6'd0;
        hi      = (word_reg == end_word_reg) ?
                  7'(re_reg - (AW'(word_reg) << 6)) : 7'd64;
        mask_lo = {64{1'b1}} << lo;
        mask_hi = (hi == 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << hi[5:0]);
        fmask   = mask_lo & mask_hi;
        gsum    = (CW+1)'(gfc_rd) + (CW+1)'(pop);
        tsum    = (TCW+1)'(total_reg) + (TCW+1)'(pop);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (word_reg == WAW'(WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_START;
            end
            ST_START: begin
                if (op_reg == OP_FREE) begin
                    if (free_bad || len_reg == '0) state_next = ST_DONE;
                    else state_next = ST_FR_RD;
                end else if (reserve_hit && !priv_reg) begin
                    state_next = ST_DONE;
                end else if (gfc_rd == '0) begin
                    state_next = ST_GRP_SEL;
                end else begin
                    state_next = ST_GOAL_RD;
                end
            end
            ST_GOAL_RD: state_next = ST_GOAL_CHK;
            ST_GOAL_CHK: begin
                if (goal_hit) state_next = ST_COMMIT;
                else if (off_reg != '0 && word_last) state_next = ST_GRP_SEL;
                else state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (bf_hit) begin
                    state_next = (bf_need_prev && !prev_ok_reg) ? ST_BACK_RD : ST_COMMIT;
                end else if (word_last) begin
                    if (fz_vld_reg || zf_hit) state_next = ST_COMMIT;
                    else if (gphase_reg) state_next = ST_GRP_SEL;
                    else state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_GRP_SEL: begin
                if (gfc_rd != '0) state_next = ST_SCAN_RD;
                else if (gcnt_reg == GW'(GROUPS - 1)) state_next = ST_DONE;
            end
            ST_BACK_RD: state_next = ST_BACK_LD;
            ST_BACK_LD: state_next = ST_COMMIT;
            ST_COMMIT:  state_next = ST_DONE;
            ST_FR_RD:   state_next = ST_FR_WR;
            ST_FR_WR: begin
                if (word_reg == end_word_reg) state_next = ST_DONE;
                else state_next = ST_FR_RD;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = word_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = word_reg;
        mem_wr_data = '0;
        unique case (state_reg)
            ST_INIT: begin
                mem_wr_en = 1'b1;
            end
            ST_GOAL_RD, ST_SCAN_RD, ST_FR_RD: begin
                mem_rd_en = 1'b1;
            end
            ST_BACK_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = found_word_reg - 1'b1;
            end
            ST_FR_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data & ~fmask;
            end
            ST_COMMIT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = fword;
                mem_wr_data = commit_data;
            end
            default: begin
            end
        endcase
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            word_reg     <= '0;
            fdb_reg      <= 1'b1;
            rsv_reg      <= '0;
            total_reg    <= TCW'(TOTAL);
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < GROUPS; i++) begin
                gfc_reg[i] <= CW'(GROUP_BLOCKS);
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_FIRST_DATA: fdb_reg <= cfg_wdata[0];
                    REG_RESERVED:   rsv_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {5'b0, OUT_W'(total_reg), dbl_reg, freed_reg, alloc_reg};
                m_tuser_reg  <= sts_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT: begin
                    word_reg <= word_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg   <= s_tuser[0];
                        blk_reg  <= s_tdata[15:0];
                        len_reg  <= s_tdata[29:16];
                        priv_reg <= s_tdata[30];
                    end
                end
                ST_START: begin
                    sts_reg     <= STS_OK;
                    alloc_reg   <= '0;
                    freed_reg   <= '0;
                    dbl_reg     <= 1'b0;
                    fz_vld_reg  <= 1'b0;
                    prev_ok_reg <= 1'b0;
                    gphase_reg  <= 1'b1;
                    gcnt_reg    <= '0;
                    if (op_reg == OP_FREE) begin
                        if (free_bad) sts_reg <= STS_RANGE;
                        rs_reg       <= rel_start;
                        re_reg       <= rel_end;
                        word_reg     <= WAW'(rel_start >> 6);
                        end_word_reg <= WAW'((rel_end - 1'b1) >> 6);
                    end else begin
                        if (reserve_hit && !priv_reg) sts_reg <= STS_NO_SPACE;
                        g_reg    <= goal_grp;
                        word_reg <= goal_word;
                        off_reg  <= goal_off;
                    end
                end
                ST_GOAL_CHK: begin
                    if (goal_hit) begin
                        found_word_reg <= word_reg;
                        found_off_reg  <= zf_pos;
                        found_data_reg <= mem_rd_data;
                        back_reg       <= 1'b0;
                    end else if (off_reg != '0) begin
                        word_reg <= word_reg + 1'b1;
                    end
                end
                ST_SCAN_CHK: begin
                    if (bf_hit) begin
                        found_word_reg <= word_reg;
                        found_off_reg  <= {bf_pos, 3'b000};
                        found_data_reg <= mem_rd_data;
                        back_reg       <= 1'b1;
                    end else begin
                        if (!fz_vld_reg && zf_hit) begin
                            fz_vld_reg  <= 1'b1;
                            fz_word_reg <= word_reg;
                            fz_off_reg  <= zf_pos;
                            fz_data_reg <= mem_rd_data;
                        end
                        prev_data_reg <= mem_rd_data;
                        prev_ok_reg   <= 1'b1;
                        back_reg      <= 1'b0;
                        if (word_last) begin
                            if (fz_vld_reg) begin
                                found_word_reg <= fz_word_reg;
                                found_off_reg  <= fz_off_reg;
                                found_data_reg <= fz_data_reg;
                            end else if (zf_hit) begin
                                found_word_reg <= word_reg;
                                found_off_reg  <= zf_pos;
                                found_data_reg <= mem_rd_data;
                            end else if (!gphase_reg) begin
                                sts_reg <= STS_CORRUPT;
                            end
                        end else begin
                            word_reg <= word_reg + 1'b1;
                        end
                    end
                end
                ST_GRP_SEL: begin
                    g_reg    <= grp_next;
                    gcnt_reg <= gcnt_reg + 1'b1;
                    if (gfc_rd != '0) begin
                        word_reg    <= WAW'(int'(grp_next) * WPG);
                        gphase_reg  <= 1'b0;
                        fz_vld_reg  <= 1'b0;
                        prev_ok_reg <= 1'b0;
                    end else if (gcnt_reg == GW'(GROUPS - 1)) begin
                        sts_reg <= STS_NO_SPACE;
                    end
                end
                ST_BACK_LD: begin
                    prev_data_reg <= mem_rd_data;
                end
                ST_COMMIT: begin
                    alloc_reg <= OUT_W'(fpos + fdb_x);
                    if (gfc_reg[g_reg] != '0) gfc_reg[g_reg] <= gfc_reg[g_reg] - 1'b1;
                    if (total_reg != '0) total_reg <= total_reg - 1'b1;
                end
                ST_FR_WR: begin
                    gfc_reg[word_grp] <= (gsum > (CW+1)'(GROUP_BLOCKS)) ?
                                         CW'(GROUP_BLOCKS) : CW'(gsum);
                    total_reg <= (tsum > (TCW+1)'(TOTAL)) ? TCW'(TOTAL) : TCW'(tsum);
                    freed_reg <= freed_reg + OUT_W'(pop);
                    if ((fmask & ~mem_rd_data) != '0) dbl_reg <= 1'b1;
                    word_reg <= word_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `GBBA_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_START)
    `GBBA_ASSERT_IMP(a_no_ram_collide, aclk, aresetn, mem_rd_en && mem_wr_en, mem_rd_addr != mem_wr_addr)
    `GBBA_ASSERT_IMP(a_total_bound, aclk, aresetn, 1'b1, total_reg <= TCW'(TOTAL))
    `GBBA_ASSERT_NXT(a_commit_takes_one, aclk, aresetn, state_reg == ST_COMMIT && total_reg != '0, total_reg == $past(total_reg) - 1'b1)

endmodule

>>> rtl/core/gbba_bitmap_ram.sv
// Used-block bitmap storage: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gbba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data
);

    logic [63:0] mem_reg [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/gbba_word_scan.sv
// Per-word search logic: first clear bit, first wholly free byte,
// popcount and step-back count. Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_word_scan (
    input  logic [63:0] word,
    input  logic [5:0]  from_off,
    input  logic [63:0] pop_word,
    input  logic [6:0]  back_bits,
    output logic        zf_hit,
    output logic [5:0]  zf_pos,
    output logic        bf_hit,
    output logic [2:0]  bf_pos,
    output logic [6:0]  pop,
    output logic [2:0]  back_cnt
);
    import gbba_pkg::*;

    always_comb begin
        zf_hit = 1'b0;
        zf_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i] && (6'(i) >= from_off)) begin
                zf_hit = 1'b1;
                zf_pos = 6'(i);
            end
        end
    end

    always_comb begin
        bf_hit = 1'b0;
        bf_pos = '0;
        for (int b = 7; b >= 0; b--) begin
            if (word[b*8 +: 8] == 8'h00) begin
                bf_hit = 1'b1;
                bf_pos = 3'(b);
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            pop = pop + 7'(pop_word[i]);
        end
    end

    // clear bits directly below the hit, counted from the top down
    always_comb begin
        logic stop;
        stop     = 1'b0;
        back_cnt = '0;
        for (int i = 6; i >= 0; i--) begin
            if (!stop && !back_bits[i]) begin
                back_cnt = back_cnt + 3'd1;
            end else begin
                stop = 1'b1;
            end
        end
    end

endmodule

>>> tb/goal_bitmap_block_allocator_tb.sv
// Self-checking testbench for goal_bitmap_block_allocator: directed, fill and random
// allocate/free traffic checked against an in-bench bitmap predictor.
// Depends on gbba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module goal_bitmap_block_allocator_tb;
    import gbba_pkg::*;

    localparam int GROUPS       = 8;
    localparam int GROUP_BLOCKS = 1024;
    localparam int TOTAL        = GROUPS * GROUP_BLOCKS;
    localparam int STALL_LIMIT  = 20000;

    typedef struct {
        gbba_status_t status;
        logic [13:0]  block;
        logic [13:0]  freed;
        logic         dbl;
        logic [13:0]  total;
    } alloc_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    goal_bitmap_block_allocator #(
        .GROUPS      (GROUPS),
        .GROUP_BLOCKS(GROUP_BLOCKS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state
    bit            used_map [TOTAL];
    int            grp_free [GROUPS];
    int            total_free;
    int            first_blk;
    int            reserve;
    alloc_result_t pending_results [$];
    int            live_blocks [$];

    int errors;
    int n_items, n_alloc_ok, n_no_space, n_range, n_double;
    int hold_cycles;
    bit no_idle;
    int quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit is_used(int g, int j);
        if (g >= GROUPS || j < 0 || j >= GROUP_BLOCKS) return 1'b1;
        return used_map[g * GROUP_BLOCKS + j];
    endfunction

    function automatic int find_zero(int g, int from, int to);
        for (int j = from; j < to; j++)
            if (!is_used(g, j)) return j;
        return to;
    endfunction

    function automatic int find_free_byte(int g, int b0, int nbytes);
        bit ok;
        for (int b = b0; b < b0 + nbytes; b++) begin
            ok = 1'b1;
            for (int t = 0; t < 8; t++)
                if (is_used(g, b * 8 + t)) ok = 1'b0;
            if (ok) return b * 8;
        end
        return GROUP_BLOCKS;
    endfunction

    task automatic predict_item(input bit op, input int blk, input int len, input bit priv,
                                output alloc_result_t r);
        int goal, g, j, k, e, rel;
        bit found, back, any;
        r.status = STS_OK;
        r.block = '0;
        r.freed = '0;
        r.dbl = 1'b0;
        found = 1'b0;
        back = 1'b0;
        any = 1'b0;
        if (op == OP_FREE) begin
            if (blk < first_blk || blk + len > first_blk + TOTAL) begin
                r.status = STS_RANGE;
            end else begin
                for (int t = 0; t < len; t++) begin
                    rel = blk - first_blk + t;
                    g = rel / GROUP_BLOCKS;
                    j = rel % GROUP_BLOCKS;
                    if (!is_used(g, j)) begin
                        r.dbl = 1'b1;
                    end else begin
                        used_map[rel] = 1'b0;
                        r.freed++;
                        if (grp_free[g] < GROUP_BLOCKS) grp_free[g]++;
                        if (total_free < TOTAL) total_free++;
                    end
                end
            end
        end else if (total_free <= reserve && !priv) begin
            r.status = STS_NO_SPACE;
        end else begin
            goal = blk;
            if (goal < first_blk || goal >= first_blk + TOTAL) goal = first_blk;
            g = (goal - first_blk) / GROUP_BLOCKS;
            j = (goal - first_blk) % GROUP_BLOCKS;
            if (grp_free[g] > 0) begin
                if (!is_used(g, j)) begin
                    found = 1'b1;
                end else begin
                    if (j != 0) begin
                        e = (j + 63) & ~63;
                        if (e > GROUP_BLOCKS) e = GROUP_BLOCKS;
                        k = find_zero(g, j, e);
                        if (k < e) found = 1'b1;
                        j = k;
                    end
                    if (!found) begin
                        k = find_free_byte(g, j >> 3, (GROUP_BLOCKS - j + 7) >> 3);
                        if (k < GROUP_BLOCKS) begin
                            j = k;
                            found = 1'b1;
                            back = 1'b1;
                        end
                    end
                    if (!found) begin
                        k = find_zero(g, j, GROUP_BLOCKS);
                        if (k < GROUP_BLOCKS) begin
                            j = k;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (!found) begin
                for (k = 0; k < GROUPS && !any; k++) begin
                    g = (g + 1) % GROUPS;
                    if (grp_free[g] > 0) any = 1'b1;
                end
                if (!any) begin
                    r.status = STS_NO_SPACE;
                end else begin
                    j = find_free_byte(g, 0, GROUP_BLOCKS >> 3);
                    if (j < GROUP_BLOCKS) begin
                        found = 1'b1;
                        back = 1'b1;
                    end else begin
                        j = find_zero(g, 0, GROUP_BLOCKS);
                        if (j < GROUP_BLOCKS) found = 1'b1;
                        else r.status = STS_CORRUPT;
                    end
                end
            end
            if (found) begin
                if (back)
                    for (k = 0; k < 7 && j > 0 && !is_used(g, j - 1); k++) j--;
                used_map[g * GROUP_BLOCKS + j] = 1'b1;
                if (grp_free[g] > 0) grp_free[g]--;
                if (total_free > 0) total_free--;
                r.block = 14'(j + g * GROUP_BLOCKS + first_blk);
                live_blocks.push_back(j + g * GROUP_BLOCKS + first_blk);
            end
        end
        r.total = 14'(total_free);
        if (r.status == STS_OK && op == OP_ALLOC) n_alloc_ok++;
        if (r.status == STS_NO_SPACE) n_no_space++;
        if (r.status == STS_RANGE) n_range++;
        if (r.dbl) n_double++;
    endtask

    // one transaction on the input channel; s_tvalid stays high into a back-to-back item
    task automatic send_item(input bit op, input int blk, input int len, input bit priv);
        alloc_result_t r;
        if (!no_idle && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 13);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, priv, 14'(len), 16'(blk)};
        do @(posedge aclk); while (!s_tready);
        predict_item(op, blk, len, priv, r);
        pending_results.push_back(r);
        n_items++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FIRST_DATA) first_blk = value & 1;
        else reserve = value & 16'h3FFF;
        @(posedge aclk);
    endtask

    task automatic send_random_item();
        int blk, len, pick;
        bit op;
        op  = ($urandom_range(99) < 40);
        len = $urandom_range(1, 8);
        pick = $urandom_range(99);
        if (pick < 10) len = $urandom_range(1, 300);
        else if (pick < 14) len = 0;
        else if (pick < 18) len = $urandom_range(16383);
        if ($urandom_range(99) < 12) blk = $urandom_range(16'hFFFF);
        else blk = first_blk + $urandom_range(TOTAL - 1);
        if (op == OP_FREE && live_blocks.size() != 0 && $urandom_range(99) < 70) begin
            pick = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[pick];
            live_blocks.delete(pick);
            len = $urandom_range(1, 3);
        end
        send_item(op, blk, len, $urandom_range(1));
    endtask

    task automatic test_directed();
        send_item(OP_ALLOC, 1, 0, 1'b0);
        send_item(OP_ALLOC, 1, 0, 1'b0);
        send_item(OP_ALLOC, 0, 0, 1'b1);
        send_item(OP_ALLOC, 16'hFFFF, 16383, 1'b0);
        send_item(OP_ALLOC, 8192, 0, 1'b0);
        send_item(OP_ALLOC, 8192, 0, 1'b0);
        send_item(OP_ALLOC, 1024, 0, 1'b0);
        send_item(OP_ALLOC, 1025, 0, 1'b0);
        send_item(OP_FREE, 1, 3, 1'b0);
        send_item(OP_FREE, 1, 3, 1'b1);
        send_item(OP_FREE, 0, 1, 1'b0);
        send_item(OP_FREE, 8190, 4, 1'b0);
        send_item(OP_FREE, 5, 0, 1'b0);
        send_item(OP_FREE, 1020, 10, 1'b0);
        send_item(OP_FREE, 16'hFFFF, 16383, 1'b1);
        wait_drain();
        write_reg(REG_RESERVED, 8192);
        send_item(OP_ALLOC, 100, 0, 1'b0);
        send_item(OP_ALLOC, 100, 0, 1'b1);
        wait_drain();
        write_reg(REG_RESERVED, 0);
        write_reg(REG_FIRST_DATA, 0);
        send_item(OP_ALLOC, 0, 0, 1'b0);
        send_item(OP_ALLOC, 8192, 0, 1'b0);
        send_item(OP_FREE, 8191, 1, 1'b0);
        send_item(OP_FREE, 8191, 2, 1'b0);
        wait_drain();
    endtask

    // packs allocations around one goal so the window, byte and bit searches move on,
    // then frees the whole zone twice
    task automatic test_fill();
        write_reg(REG_FIRST_DATA, 1);
        for (int i = 0; i < 16; i++) send_item(OP_ALLOC, 200, 0, 1'b0);
        send_item(OP_ALLOC, 200, 0, 1'b1);
        send_item(OP_ALLOC, 1023, 0, 1'b0);
        send_item(OP_FREE, first_blk, TOTAL, 1'b0);
        send_item(OP_FREE, first_blk, TOTAL, 1'b0);
        wait_drain();
        live_blocks.delete();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++) send_random_item();
        wait_drain();
    endtask

    task automatic test_random(input int fdb, input int res, input int count, input bit quiet);
        write_reg(REG_FIRST_DATA, fdb);
        write_reg(REG_RESERVED, res);
        no_idle = quiet;
        for (int i = 0; i < count; i++) send_random_item();
        wait_drain();
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        alloc_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction: %h/%h", m_tuser, m_tdata);
            end else begin
                e = pending_results.pop_front();
                if (m_tuser != e.status || m_tdata[13:0] != e.block ||
                    m_tdata[27:14] != e.freed || m_tdata[28] != e.dbl ||
                    m_tdata[42:29] != e.total || m_tdata[47:43] != '0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp sts %0d blk %0d freed %0d dbl %0d tot %0d, got sts %0d blk %0d freed %0d dbl %0d tot %0d",
                                 e.status, e.block, e.freed, e.dbl, e.total, m_tuser,
                                 m_tdata[13:0], m_tdata[27:14], m_tdata[28], m_tdata[42:29]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int res;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        hold_cycles = 0;
        no_idle = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        for (int i = 0; i < TOTAL; i++) used_map[i] = 1'b0;
        for (int g = 0; g < GROUPS; g++) grp_free[g] = GROUP_BLOCKS;
        total_free = TOTAL;
        first_blk = 1;
        reserve = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill();
        test_backpressure();
        test_random(1, 0, 110, 1'b0);
        test_random(0, 8192, 60, 1'b0);
        res = total_free - $urandom_range(40);
        test_random(1, res, 110, 1'b1);
        res = total_free + $urandom_range(3);
        test_random(0, res, 110, 1'b0);
        test_random(1, 0, 110, 1'b0);

        s_tvalid <= 1'b0;
        repeat (50) @(posedge aclk);
        $display("%0d transactions: %0d allocations, %0d no-space, %0d out-of-zone frees, %0d double frees",
                 n_items, n_alloc_ok, n_no_space, n_range, n_double);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, pending_results.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/gbba_pkg.sv
rtl/core/gbba_bitmap_ram.sv
rtl/core/gbba_word_scan.sv
rtl/core/goal_bitmap_block_allocator.sv
tb/goal_bitmap_block_allocator_tb.sv
